>>> sv/rtwd_pkg.sv
package rtwd_pkg;

  localparam int TICK_W  = 6;
  localparam int ACC_W   = 11;
  localparam int DIV_W   = 16;
  localparam int CTRL_W  = 3;

  localparam logic [DIV_W-1:0]  DIV_RESET     = 16'hAB00;
  localparam int                CTRL_EN_BIT   = 2;
  localparam logic [7:0]        CTRL_RD_FILL  = 8'hF8;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_DIV    = 2'd0,
    REG_CNT    = 2'd1,
    REG_RELOAD = 2'd2,
    REG_CTRL   = 2'd3
  } reg_sel_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOP,
    ST_DONE
  } state_e;

  // Prescale period picked by the low control bits.
  function automatic logic [ACC_W-1:0] period_f(input logic [1:0] sel);
    logic [ACC_W-1:0] p;
    case (sel)
      2'd0:    p = 11'd1024;
      2'd1:    p = 11'd16;
      2'd2:    p = 11'd64;
      2'd3:    p = 11'd256;
      default: p = 11'd1024;
    endcase
    return p;
  endfunction

endpackage

>>> sv/reload_timer_with_divider_core.sv
// Prescaled timer with reload.
//
// Input channel (in_valid_i / in_stall_o) carries one command word: a tick of
// elapsed cycles, a register read or a register write. Every accepted word
// gives exactly one output word (out_valid_o / out_stall_i) with read_data_o
// (register byte on a read, zero otherwise) and timer_irq_o (counter wrapped
// at least once during a tick).
//
// Path: a read, a write, an unused command or a tick with the timer off goes
// from acceptance to the done state, then into the output register. An enabled
// tick first runs the loop state: one shared compare-and-subtract on the
// prescale accumulator retires one period per cycle until less than a period
// is left. The input is stalled from acceptance until the result has moved
// into the output register, so one word is in flight at a time.
//
// When the receiver stalls, the output word holds; a finished result waits in
// the core until the output register frees, and the input stays stalled.
// Reset sets the divider to 0xAB00, clears counter, reload, control and the
// accumulator, and empties the output register.
module reload_timer_with_divider_core
  import rtwd_pkg::*;
#(
  parameter int MAX_TICK_CYCLES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [1:0]  reg_select_i,
  input  logic [7:0]  write_data_i,
  input  logic [5:0]  tick_cycles_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        timer_irq_o
);

  localparam int CYC_W = $clog2(MAX_TICK_CYCLES + 1);
  localparam int CMP_W = (CYC_W > TICK_W) ? CYC_W : TICK_W;
  localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_TICK_CYCLES);

  state_e state_q, state_d;

  logic [DIV_W-1:0]  div_q, div_d;
  logic [7:0]        cnt_q, cnt_d;
  logic [7:0]        reload_q, reload_d;
  logic [CTRL_W-1:0] ctrl_q, ctrl_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [7:0]        rd_q, rd_d;
  logic              irq_q, irq_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_data_q, out_data_d;
  logic              out_irq_q, out_irq_d;

  logic [CMP_W-1:0]  tick_ext;
  logic [CYC_W-1:0]  cyc;
  logic [ACC_W-1:0]  period;
  logic              accept;
  logic              out_free;

  assign tick_ext = CMP_W'(tick_cycles_i);
  assign cyc      = (tick_ext > MAX_EXT) ? CYC_W'(MAX_EXT) : CYC_W'(tick_ext);
  assign period   = period_f(ctrl_q[1:0]);
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign timer_irq_o = out_irq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    div_d       = div_q;
    cnt_d       = cnt_q;
    reload_d    = reload_q;
    ctrl_d      = ctrl_q;
    acc_d       = acc_q;
    rd_d        = rd_q;
    irq_d       = irq_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    out_irq_d   = out_irq_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rd_d    = '0;
          irq_d   = 1'b0;
          state_d = ST_DONE;
          case (cmd_e'(command_i))
            CMD_TICK: begin
              div_d = div_q + DIV_W'(cyc);
              if (ctrl_q[CTRL_EN_BIT]) begin
                acc_d   = acc_q + ACC_W'(cyc);
                state_d = ST_LOOP;
              end
            end
            CMD_READ: begin
              case (reg_sel_e'(reg_select_i))
                REG_DIV:    rd_d = div_q[DIV_W-1 -: 8];
                REG_CNT:    rd_d = cnt_q;
                REG_RELOAD: rd_d = reload_q;
                REG_CTRL:   rd_d = CTRL_RD_FILL | 8'(ctrl_q);
                default:    rd_d = '0;
              endcase
            end
            CMD_WRITE: begin
              case (reg_sel_e'(reg_select_i))
                REG_DIV:    div_d = '0;
                REG_CNT:    cnt_d = write_data_i;
                REG_RELOAD: reload_d = write_data_i;
                REG_CTRL:   ctrl_d = write_data_i[CTRL_W-1:0];
                default:    ctrl_d = ctrl_q;
              endcase
            end
            default: rd_d = '0;
          endcase
        end
      end

      // Retire one prescale period per cycle.
      ST_LOOP: begin
        if (acc_q >= period) begin
          acc_d = acc_q - period;
          if (cnt_q == 8'hFF) begin
            cnt_d = reload_q;
            irq_d = 1'b1;
          end else begin
            cnt_d = cnt_q + 8'd1;
          end
        end else begin
          state_d = ST_DONE;
        end
      end

      // Hold the result until the output register frees.
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = rd_q;
          out_irq_d   = irq_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q       <= DIV_RESET;
      cnt_q       <= '0;
      reload_q    <= '0;
      ctrl_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      div_q       <= div_d;
      cnt_q       <= cnt_d;
      reload_q    <= reload_d;
      ctrl_q      <= ctrl_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q       <= rd_d;
    irq_q      <= irq_d;
    out_data_q <= out_data_d;
    out_irq_q  <= out_irq_d;
  end

endmodule

>>> sv/rtwd_checker.sv
module rtwd_checker
  import rtwd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] command_i,
  input logic [1:0] reg_select_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_data_o,
  input logic       timer_irq_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // Stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(read_data_o) && $stable(timer_irq_o))
    else $error("output word changed while stalled");

  // One word at a time: busy right after acceptance.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input accepted while previous word in flight");

  // Interrupt only comes from ticks, whose read data is zero.
  a_irq_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && timer_irq_o |-> read_data_o == 8'h00)
    else $error("interrupt with nonzero read data");

  // Non-tick word reaches an empty output straight through the done state.
  a_fast_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o && (command_i != CMD_TICK) |-> ##2 out_valid_o)
    else $error("non-tick result late");

  // Control read shows the fill bits.
  a_ctrl_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o && (command_i == CMD_READ) && (reg_select_i == REG_CTRL)
      |-> ##2 (read_data_o[7:3] == 5'h1F) && !timer_irq_o)
    else $error("control read without fill bits");

endmodule

bind reload_timer_with_divider_core rtwd_checker u_rtwd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .command_i    (command_i),
  .reg_select_i (reg_select_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .read_data_o  (read_data_o),
  .timer_irq_o  (timer_irq_o)
);
